// File: rtl/core/cvc_pkg.sv
// shared types and constants for the cyrillic vigenere cipher
package cvc_pkg;

	localparam int unsigned MAX_KEY_LETTERS = 40;
	localparam int unsigned ALPHABET_SIZE   = 33;
	localparam int unsigned LETTERS_PER_REG = 10;
	localparam int unsigned KEY_REGS        = 4;
	localparam int unsigned KEY_REG_W       = 60;
	localparam int unsigned LETTER_W        = 6;
	localparam int unsigned CHAR_W          = 16;
	localparam int unsigned CFG_DATA_W      = 60;

	localparam logic [CHAR_W-1:0] CP_UPPER_FIRST = 16'h0410;
	localparam logic [CHAR_W-1:0] CP_UPPER_LAST  = 16'h042F;
	localparam logic [CHAR_W-1:0] CP_LOWER_FIRST = 16'h0430;
	localparam logic [CHAR_W-1:0] CP_LOWER_LAST  = 16'h044F;
	localparam logic [CHAR_W-1:0] CP_UPPER_YO    = 16'h0401;
	localparam logic [CHAR_W-1:0] CP_LOWER_YO    = 16'h0451;
	localparam logic [CHAR_W-1:0] CASE_DISTANCE  = 16'd32;
	localparam logic [CHAR_W-1:0] YO_DISTANCE    = 16'd80;
	localparam logic [LETTER_W-1:0] YO_INDEX     = 6'd6;
	localparam logic [LETTER_W-1:0] ALPHA_N      = 6'd33;
	localparam logic [LETTER_W-1:0] MAX_LEN      = 6'd40;

	// configuration register indexes
	typedef enum logic [2:0] {
		CFG_DIRECTION = 3'd0,
		CFG_KEY_LEN   = 3'd1,
		CFG_KEY_A     = 3'd2,
		CFG_KEY_B     = 3'd3,
		CFG_KEY_C     = 3'd4,
		CFG_KEY_D     = 3'd5
	} cfg_index_t;

	// classified character passed from front to back
	typedef struct packed {
		logic                eot;
		logic                bad;
		logic                have;
		logic [LETTER_W-1:0] idx;
	} cvc_item_t;

endpackage

// File: rtl/core/cvc_front.sv
// front part: folds case and maps a code point to an alphabet index
module cvc_front (
	input  logic                      direction,
	input  logic [cvc_pkg::CHAR_W-1:0] in_char,
	input  logic                      end_of_text,
	output cvc_pkg::cvc_item_t        item
);
	import cvc_pkg::*;

	logic [CHAR_W-1:0] up;
	logic [CHAR_W-1:0] off;
	logic              is_letter;

	// case folding, encrypt mode only
	always_comb begin
		up = in_char;
		if (!direction) begin
			if (in_char >= CP_LOWER_FIRST && in_char <= CP_LOWER_LAST) begin
				up = in_char - CASE_DISTANCE;
			end else if (in_char == CP_LOWER_YO) begin
				up = in_char - YO_DISTANCE;
			end
		end
	end

	// uppercase code point to index, yo sits after the sixth letter
	always_comb begin
		off       = up - CP_UPPER_FIRST;
		is_letter = 1'b0;
		item.idx  = '0;
		if (up == CP_UPPER_YO) begin
			is_letter = 1'b1;
			item.idx  = YO_INDEX;
		end else if (up >= CP_UPPER_FIRST && up <= CP_UPPER_LAST) begin
			is_letter = 1'b1;
			if (off[LETTER_W-1:0] < YO_INDEX) begin
				item.idx = off[LETTER_W-1:0];
			end else begin
				item.idx = off[LETTER_W-1:0] + 6'd1;
			end
		end
		item.have = is_letter;
		item.bad  = direction & ~is_letter;
		item.eot  = end_of_text;
	end

endmodule

// File: rtl/core/cvc_queue.sv
// small fifo between front and back
module cvc_queue #(
	parameter int unsigned WIDTH = 9,
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             push_ready,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             pop_valid
);
	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != FULL_CNT);
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push & push_ready;
	assign do_pop     = pop & pop_valid;

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!do_push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= FULL_CNT)
		else $error("queue fill count beyond depth");

endmodule

// File: rtl/core/cvc_back.sv
// back part: key position tracking, modulo 33 shift and output register
module cvc_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           direction,
	input  logic [cvc_pkg::LETTER_W-1:0]   key_length,
	input  logic [cvc_pkg::KEY_REG_W-1:0]  key_regs [cvc_pkg::KEY_REGS],
	input  cvc_pkg::cvc_item_t             item,
	input  logic                           item_valid,
	output logic                           item_pop,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [cvc_pkg::CHAR_W-1:0]     out_char,
	output logic                           kept,
	output logic                           bad_char,
	output logic                           end_of_result
);
	import cvc_pkg::*;

	logic [LETTER_W-1:0] pos_q;
	logic [1:0]          grp_q;
	logic [3:0]          sub_q;
	logic                out_valid_q;
	logic [CHAR_W-1:0]   out_char_q;
	logic                out_kept_q;
	logic                out_bad_q;
	logic                out_eot_q;

	logic [LETTER_W-1:0] len;
	logic [LETTER_W-1:0] pos_use;
	logic [1:0]          grp_use;
	logic [3:0]          sub_use;
	logic [LETTER_W-1:0] pos_nxt;
	logic [1:0]          grp_nxt;
	logic [3:0]          sub_nxt;
	logic [KEY_REG_W-1:0] key_word;
	logic [LETTER_W-1:0] letters [LETTERS_PER_REG];
	logic [LETTER_W-1:0] k6;
	logic [LETTER_W-1:0] k;
	logic [LETTER_W:0]   sum;
	logic [LETTER_W:0]   r7;
	logic [LETTER_W-1:0] r;
	logic [CHAR_W-1:0]   res_cp;

	assign item_pop = item_valid & (~out_valid_q | out_ready);

	// effective key length
	always_comb begin
		if (key_length == '0) begin
			len = 6'd1;
		end else if (key_length > MAX_LEN) begin
			len = MAX_LEN;
		end else begin
			len = key_length;
		end
	end

	// restart if the length shrank to or below the current position
	always_comb begin
		if (pos_q >= len) begin
			pos_use = '0;
			grp_use = '0;
			sub_use = '0;
		end else begin
			pos_use = pos_q;
			grp_use = grp_q;
			sub_use = sub_q;
		end
	end

	// key letter select, register then letter within it
	assign key_word = key_regs[grp_use];
	for (genvar g = 0; g < LETTERS_PER_REG; g++) begin : g_letters
		assign letters[g] = key_word[g*LETTER_W +: LETTER_W];
	end
	assign k6 = letters[sub_use];
	assign k  = (k6 >= ALPHA_N) ? k6 - ALPHA_N : k6;

	// modulo 33 add or subtract
	always_comb begin
		if (direction) begin
			sum = {1'b0, item.idx} + {1'b0, ALPHA_N} - {1'b0, k};
		end else begin
			sum = {1'b0, item.idx} + {1'b0, k};
		end
		r7 = (sum >= {1'b0, ALPHA_N}) ? sum - {1'b0, ALPHA_N} : sum;
		r  = r7[LETTER_W-1:0];
	end

	// index back to an uppercase code point
	always_comb begin
		if (r == YO_INDEX) begin
			res_cp = CP_UPPER_YO;
		end else if (r < YO_INDEX) begin
			res_cp = CP_UPPER_FIRST + {10'd0, r};
		end else begin
			res_cp = CP_UPPER_FIRST - 16'd1 + {10'd0, r};
		end
	end

	// next key position, group and letter counters step together
	always_comb begin
		pos_nxt = pos_q;
		grp_nxt = grp_q;
		sub_nxt = sub_q;
		if (item.have) begin
			if (pos_use + 6'd1 >= len) begin
				pos_nxt = '0;
				grp_nxt = '0;
				sub_nxt = '0;
			end else begin
				pos_nxt = pos_use + 6'd1;
				if (sub_use == 4'(LETTERS_PER_REG - 1)) begin
					grp_nxt = grp_use + 2'd1;
					sub_nxt = '0;
				end else begin
					grp_nxt = grp_use;
					sub_nxt = sub_use + 4'd1;
				end
			end
		end
		if (item.eot) begin
			pos_nxt = '0;
			grp_nxt = '0;
			sub_nxt = '0;
		end
	end

	// key position state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			grp_q       <= '0;
			sub_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (item_pop) begin
				pos_q       <= pos_nxt;
				grp_q       <= grp_nxt;
				sub_q       <= sub_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output payload register
	always_ff @(posedge clk) begin
		if (item_pop) begin
			out_char_q <= item.have ? res_cp : '0;
			out_kept_q <= item.have;
			out_bad_q  <= item.bad;
			out_eot_q  <= item.eot;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_char      = out_char_q;
	assign kept          = out_kept_q;
	assign bad_char      = out_bad_q;
	assign end_of_result = out_eot_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_kept_q && out_bad_q))
		else $error("result both kept and flagged bad");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_kept_q |-> out_char_q == '0)
		else $error("dropped character carries a code point");

	assert property (@(posedge clk) disable iff (!arst_n)
		item_pop && item.eot |=> pos_q == '0 && grp_q == '0 && sub_q == '0)
		else $error("key position not cleared after end of text");

	assert property (@(posedge clk) disable iff (!arst_n)
		pos_q < MAX_LEN)
		else $error("key position out of range");

endmodule

// File: rtl/core/cyrillic_vigenere_cipher_top.sv
// Vigenere cipher over the 33-letter Russian alphabet, one character per transaction.
//
// Input stream s_axis carries one code point in tdata and the end-of-message mark in
// tlast. Every input transaction gives exactly one output transaction on m_axis: tdata
// holds the resulting uppercase code point (zero when the character was dropped),
// tuser[0] says a letter was produced, tuser[1] flags a non-uppercase character in
// decrypt mode, tlast copies the input mark.
// The cfg channel writes direction, key length and the four packed key words; it is
// always ready and must be written only while no message is in flight; the block does
// not enforce this. The classifier writes the two-entry queue on input acceptance and
// the key shift unit then loads the output register from the queue.
// Throughput is one character per cycle while m_axis does not stall, set by the key
// position registers, which are updated once per character in the back part.
// When m_axis stalls, the output register holds and the queue absorbs up to two more
// characters before s_axis_tready drops.
// Reset clears the key position, the queue and the configuration to encrypt mode,
// key length one and all-zero key letters.
module cyrillic_vigenere_cipher_top (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [15:0] in_char
	input  logic        s_axis_tlast,  // end_of_text
	// output stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // [15:0] out_char
	output logic [1:0]  m_axis_tuser,  // [0] kept, [1] bad_char
	output logic        m_axis_tlast,  // end_of_result
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [59:0] cfg_data
);
	import cvc_pkg::*;

	localparam int unsigned QUEUE_DEPTH = 2;

	logic                 direction_q;
	logic [LETTER_W-1:0]  key_length_q;
	logic [KEY_REG_W-1:0] key_q [KEY_REGS];
	cvc_item_t            front_item;
	cvc_item_t            back_item;
	logic [$bits(cvc_item_t)-1:0] queue_out;
	logic                 queue_ready;
	logic                 queue_valid;
	logic                 back_pop;
	logic                 cfg_we;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid & cfg_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q  <= 1'b0;
			key_length_q <= 6'd1;
			for (int i = 0; i < KEY_REGS; i++) begin
				key_q[i] <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DIRECTION: direction_q  <= cfg_data[0];
				CFG_KEY_LEN:   key_length_q <= cfg_data[LETTER_W-1:0];
				CFG_KEY_A:     key_q[0]     <= cfg_data;
				CFG_KEY_B:     key_q[1]     <= cfg_data;
				CFG_KEY_C:     key_q[2]     <= cfg_data;
				CFG_KEY_D:     key_q[3]     <= cfg_data;
				default: ;
			endcase
		end
	end

	cvc_front u_front (
		.direction   (direction_q),
		.in_char     (s_axis_tdata),
		.end_of_text (s_axis_tlast),
		.item        (front_item)
	);

	cvc_queue #(
		.WIDTH ($bits(cvc_item_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (s_axis_tvalid),
		.push_data  (front_item),
		.push_ready (queue_ready),
		.pop        (back_pop),
		.pop_data   (queue_out),
		.pop_valid  (queue_valid)
	);

	assign s_axis_tready = queue_ready;
	assign back_item     = cvc_item_t'(queue_out);

	cvc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.direction     (direction_q),
		.key_length    (key_length_q),
		.key_regs      (key_q),
		.item          (back_item),
		.item_valid    (queue_valid),
		.item_pop      (back_pop),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.out_char      (m_axis_tdata),
		.kept          (m_axis_tuser[0]),
		.bad_char      (m_axis_tuser[1]),
		.end_of_result (m_axis_tlast)
	);

endmodule

// File: tb/cyrillic_vigenere_cipher_top_tb.sv
// self-checking stream testbench for the cyrillic vigenere cipher top level
module cyrillic_vigenere_cipher_top_tb;
	import cvc_pkg::*;

	localparam int unsigned RUN_LIMIT     = 1_500_000;
	localparam int unsigned DRAIN_CYCLES  = 8;
	localparam int unsigned RANDOM_PHASES = 14;
	localparam int unsigned PHASE_CHARS   = 120;
	localparam int unsigned HOLD_CYCLES   = 100;

	// one output transaction as the checker sees it
	typedef struct packed {
		logic [CHAR_W-1:0] out_char;
		logic              kept;
		logic              bad_char;
		logic              end_of_result;
	} cipher_result_t;

	logic              clk;
	logic              arst_n;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [CHAR_W-1:0] s_axis_tdata;   // [15:0] in_char
	logic              s_axis_tlast;   // end_of_text
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [CHAR_W-1:0] m_axis_tdata;   // [15:0] out_char
	logic [1:0]        m_axis_tuser;   // [0] kept, [1] bad_char
	logic              m_axis_tlast;   // end_of_result
	logic              cfg_valid;
	logic              cfg_ready;
	cfg_index_t        cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// mirrored configuration and key position
	logic                 mdl_decrypt;
	logic [LETTER_W-1:0]  mdl_key_len;
	logic [KEY_REG_W-1:0] mdl_key_word [KEY_REGS];
	logic [LETTER_W-1:0]  mdl_key_pos;

	cipher_result_t expected_results [$];
	int unsigned    fail_count;

	// idling controls for the stimulus and the receiver
	bit          tx_gaps_on;
	bit          rx_stalls_on;
	int unsigned rx_hold_cycles;
	int unsigned rx_stall_left;

	cyrillic_vigenere_cipher_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// clock
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// hard stop if the stream hangs
	initial begin
		#(RUN_LIMIT);
		$display("cyrillic_vigenere_cipher_top regression: fail");
		$finish;
	end

	// mostly short gaps, a few long ones
	function automatic int unsigned idle_length(bit enabled);
		int unsigned roll;
		if (!enabled)
			return 0;
		roll = $urandom_range(99, 0);
		if (roll < 60)
			return 0;
		if (roll < 90)
			return $urandom_range(3, 1);
		if (roll < 98)
			return $urandom_range(10, 4);
		return $urandom_range(60, 20);
	endfunction

	// cipher step: classify, shift by the current key letter, advance position
	function automatic cipher_result_t encipher_char(logic [CHAR_W-1:0] cp, logic eot);
		cipher_result_t res;
		logic [CHAR_W-1:0] upper;
		logic found;
		int unsigned idx, len, key, sum, off;
		res   = '0;
		upper = cp;
		idx   = 0;
		if (!mdl_decrypt) begin
			if (cp >= CP_LOWER_FIRST && cp <= CP_LOWER_LAST)
				upper = cp - CASE_DISTANCE;
			else if (cp == CP_LOWER_YO)
				upper = cp - YO_DISTANCE;
		end
		found = 1'b1;
		if (upper == CP_UPPER_YO) begin
			idx = YO_INDEX;
		end else if (upper >= CP_UPPER_FIRST && upper <= CP_UPPER_LAST) begin
			off = upper - CP_UPPER_FIRST;
			idx = (off < YO_INDEX) ? off : off + 1;
		end else begin
			found = 1'b0;
		end
		if (found) begin
			len = mdl_key_len;
			if (len == 0)
				len = 1;
			if (len > MAX_KEY_LETTERS)
				len = MAX_KEY_LETTERS;
			// a shortened key restarts the position
			if (mdl_key_pos >= len)
				mdl_key_pos = '0;
			key = mdl_key_word[mdl_key_pos / LETTERS_PER_REG]
				[(mdl_key_pos % LETTERS_PER_REG) * LETTER_W +: LETTER_W];
			key = key % ALPHABET_SIZE;
			sum = mdl_decrypt ? idx + ALPHABET_SIZE - key : idx + key;
			sum = sum % ALPHABET_SIZE;
			if (sum == YO_INDEX)
				res.out_char = CP_UPPER_YO;
			else if (sum < YO_INDEX)
				res.out_char = CHAR_W'(CP_UPPER_FIRST + sum);
			else
				res.out_char = CHAR_W'(CP_UPPER_FIRST + sum - 1);
			mdl_key_pos = (mdl_key_pos + 1 >= len) ? '0 : mdl_key_pos + 1'b1;
		end
		if (eot)
			mdl_key_pos = '0;
		res.kept          = found;
		res.bad_char      = mdl_decrypt && !found;
		res.end_of_result = eot;
		return res;
	endfunction

	// one letter of the alphabet in either case
	function automatic logic [CHAR_W-1:0] cyrillic_letter(bit lower);
		int unsigned pick;
		pick = $urandom_range(32, 0);
		if (pick == 32)
			return lower ? CP_LOWER_YO : CP_UPPER_YO;
		return CHAR_W'((lower ? CP_LOWER_FIRST : CP_UPPER_FIRST) + pick);
	endfunction

	// character mix: mostly letters, then edge neighbors, ascii and anything
	function automatic logic [CHAR_W-1:0] random_char(logic decrypt);
		int unsigned roll;
		roll = $urandom_range(99, 0);
		if (decrypt && $urandom_range(99, 0) < 50)
			return cyrillic_letter(1'b0);
		if (roll < 45)
			return cyrillic_letter(1'b0);
		if (roll < 70)
			return cyrillic_letter(1'b1);
		if (roll < 80) begin
			case ($urandom_range(5, 0))
				0:       return CP_UPPER_YO - 1'b1;
				1:       return CP_UPPER_YO + 1'b1;
				2:       return CP_UPPER_FIRST - 1'b1;
				3:       return CP_LOWER_LAST + 1'b1;
				4:       return CP_LOWER_YO + 1'b1;
				default: return CP_LOWER_YO - 1'b1;
			endcase
		end
		if (roll < 90)
			return CHAR_W'($urandom_range(127, 0));
		return CHAR_W'($urandom_range(16'hFFFF, 0));
	endfunction

	// key word: zeros, ones, legal letters or raw bits
	function automatic logic [KEY_REG_W-1:0] random_key_word();
		logic [KEY_REG_W-1:0] word;
		int unsigned roll;
		roll = $urandom_range(9, 0);
		word = KEY_REG_W'({$urandom, $urandom});
		if (roll == 0)
			word = '0;
		else if (roll == 1)
			word = '1;
		else if (roll < 6)
			for (int i = 0; i < LETTERS_PER_REG; i++)
				word[i * LETTER_W +: LETTER_W] =
					LETTER_W'($urandom_range(ALPHABET_SIZE - 1, 0));
		return word;
	endfunction

	function automatic logic [LETTER_W-1:0] random_key_len();
		int unsigned roll;
		roll = $urandom_range(99, 0);
		if (roll < 15)
			return 6'd1;
		if (roll < 30)
			return MAX_LEN;
		if (roll < 40)
			return '0;
		if (roll < 50)
			return LETTER_W'($urandom_range(63, MAX_KEY_LETTERS + 1));
		return LETTER_W'($urandom_range(MAX_KEY_LETTERS, 1));
	endfunction

	// one input transaction; valid stays high into the next one when there is no gap
	task automatic send_char(input logic [CHAR_W-1:0] cp, input logic eot);
		int unsigned gap;
		gap = idle_length(tx_gaps_on);
		@(negedge clk);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= cp;
		s_axis_tlast  <= eot;
		@(posedge clk);
		while (s_axis_tready !== 1'b1)
			@(posedge clk);
		expected_results.insert(expected_results.size(), encipher_char(cp, eot));
	endtask

	task automatic send_message(input int unsigned len, input bit close);
		for (int unsigned i = 0; i < len; i++)
			send_char(random_char(mdl_decrypt), close && (i == len - 1));
	endtask

	// stop offering and wait until every result is back
	task automatic settle_block();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (cfg_ready !== 1'b1)
			@(posedge clk);
		case (idx)
			CFG_DIRECTION: mdl_decrypt     = data[0];
			CFG_KEY_LEN:   mdl_key_len     = data[LETTER_W-1:0];
			CFG_KEY_A:     mdl_key_word[0] = data;
			CFG_KEY_B:     mdl_key_word[1] = data;
			CFG_KEY_C:     mdl_key_word[2] = data;
			CFG_KEY_D:     mdl_key_word[3] = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic configure(input logic decrypt, input logic [LETTER_W-1:0] len,
		input logic [KEY_REG_W-1:0] wa, input logic [KEY_REG_W-1:0] wb,
		input logic [KEY_REG_W-1:0] wc, input logic [KEY_REG_W-1:0] wd);
		settle_block();
		write_reg(CFG_DIRECTION, CFG_DATA_W'(decrypt));
		write_reg(CFG_KEY_LEN, CFG_DATA_W'(len));
		write_reg(CFG_KEY_A, wa);
		write_reg(CFG_KEY_B, wb);
		write_reg(CFG_KEY_C, wc);
		write_reg(CFG_KEY_D, wd);
	endtask

	// reset configuration: encrypt, zero key, field extremes and case folding
	task automatic test_reset_defaults();
		send_char(16'h0000, 1'b0);
		send_char(16'hFFFF, 1'b0);
		send_char(CP_UPPER_FIRST, 1'b0);
		send_char(CP_UPPER_LAST, 1'b0);
		send_char(CP_LOWER_FIRST, 1'b0);
		send_char(CP_LOWER_LAST, 1'b0);
		send_char(CP_UPPER_YO, 1'b0);
		send_char(CP_LOWER_YO, 1'b0);
		send_char(CP_UPPER_FIRST - 1'b1, 1'b0);
		send_char(CP_LOWER_LAST + 1'b1, 1'b1);
	endtask

	// zero and oversized key length, letters above the alphabet, shortened key
	task automatic test_key_edges();
		settle_block();
		write_reg(CFG_KEY_LEN, '0);
		write_reg(CFG_KEY_A, {{(KEY_REG_W - 2 * LETTER_W){1'b0}}, 6'd33, 6'd63});
		send_char(CP_UPPER_FIRST, 1'b0);
		send_char(CP_UPPER_FIRST + 1'b1, 1'b1);
		settle_block();
		write_reg(CFG_KEY_LEN, CFG_DATA_W'(2));
		send_char(CP_UPPER_FIRST, 1'b0);
		send_char(CP_LOWER_FIRST, 1'b0);
		send_char(CP_UPPER_YO, 1'b0);
		// key position now sits past the new length
		settle_block();
		write_reg(CFG_KEY_LEN, CFG_DATA_W'(1));
		send_char(CP_UPPER_FIRST, 1'b1);
		settle_block();
		write_reg(CFG_KEY_LEN, CFG_DATA_W'(6'd63));
		write_reg(CFG_KEY_B, '1);
		write_reg(CFG_KEY_C, {LETTERS_PER_REG{6'd32}});
		write_reg(CFG_KEY_D, {LETTERS_PER_REG{6'd1}});
		send_char(CP_UPPER_LAST, 1'b0);
		send_char(CP_LOWER_YO, 1'b0);
		send_char(CP_UPPER_YO, 1'b1);
	endtask

	// decrypt accepts uppercase only, everything else is flagged
	task automatic test_decrypt_edges();
		settle_block();
		write_reg(CFG_DIRECTION, CFG_DATA_W'(1'b1));
		send_char(CP_UPPER_FIRST, 1'b0);
		send_char(CP_UPPER_YO, 1'b0);
		send_char(CP_UPPER_LAST, 1'b0);
		send_char(CP_LOWER_FIRST, 1'b0);
		send_char(CP_LOWER_YO, 1'b0);
		send_char(16'h0000, 1'b1);
	endtask

	// receiver holds off while the sender keeps pushing
	task automatic test_output_backpressure();
		configure(1'($urandom_range(1, 0)), random_key_len(), random_key_word(),
			random_key_word(), random_key_word(), random_key_word());
		tx_gaps_on   = 1'b0;
		rx_stalls_on = 1'b0;
		@(posedge clk);
		rx_hold_cycles = HOLD_CYCLES;
		send_message(25, 1'b1);
		send_message(15, 1'b1);
	endtask

	// sender pauses mid message until everything has drained
	task automatic test_input_pause();
		tx_gaps_on   = 1'b1;
		rx_stalls_on = 1'b1;
		send_message(20, 1'b0);
		settle_block();
		send_message(20, 1'b1);
	endtask

	// random messages under a series of settings
	task automatic test_random_messages();
		int unsigned sent, len;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: configure(1'b0, 6'd63, '1, '1, '1, '1);
				1: configure(1'b1, MAX_LEN, '1, '1, '1, '1);
				2: configure(1'b0, 6'd1, '0, '0, '0, '0);
				3: configure(1'b1, 6'd0, '0, '0, '0, '0);
				default: configure(1'($urandom_range(1, 0)), random_key_len(),
					random_key_word(), random_key_word(), random_key_word(),
					random_key_word());
			endcase
			tx_gaps_on   = ($urandom_range(3, 0) != 0);
			rx_stalls_on = ($urandom_range(3, 0) != 0);
			sent = 0;
			while (sent < PHASE_CHARS) begin
				len = $urandom_range(50, 1);
				if (len > PHASE_CHARS - sent)
					len = PHASE_CHARS - sent;
				send_message(len, (sent + len < PHASE_CHARS) || $urandom_range(1, 0));
				sent += len;
			end
		end
	endtask

	// receiver: long hold-off first, then random stalls
	always @(negedge clk) begin
		if (rx_hold_cycles != 0) begin
			rx_hold_cycles = rx_hold_cycles - 1;
			m_axis_tready <= 1'b0;
		end else if (rx_stall_left != 0) begin
			rx_stall_left = rx_stall_left - 1;
			m_axis_tready <= 1'b0;
		end else if (rx_stalls_on && $urandom_range(99, 0) < 25) begin
			rx_stall_left = idle_length(1'b1);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// compare each output transaction with the oldest expected result
	always @(posedge clk) begin : check_results
		cipher_result_t want;
		if (arst_n && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result: out_char %h, tuser %b", m_axis_tdata, m_axis_tuser);
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				if (m_axis_tdata !== want.out_char) begin
					$error("out_char: expected %h, actual %h", want.out_char, m_axis_tdata);
					fail_count++;
				end
				if (m_axis_tuser[0] !== want.kept) begin
					$error("kept: expected %b, actual %b", want.kept, m_axis_tuser[0]);
					fail_count++;
				end
				if (m_axis_tuser[1] !== want.bad_char) begin
					$error("bad_char: expected %b, actual %b", want.bad_char, m_axis_tuser[1]);
					fail_count++;
				end
				if (m_axis_tlast !== want.end_of_result) begin
					$error("end_of_result: expected %b, actual %b",
						want.end_of_result, m_axis_tlast);
					fail_count++;
				end
			end
		end
	end

	// sequence of tests
	initial begin
		arst_n         = 1'b0;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		s_axis_tlast   = 1'b0;
		m_axis_tready  = 1'b0;
		cfg_valid      = 1'b0;
		cfg_index      = CFG_DIRECTION;
		cfg_data       = '0;
		mdl_decrypt    = 1'b0;
		mdl_key_len    = 6'd1;
		mdl_key_pos    = '0;
		fail_count     = 0;
		tx_gaps_on     = 1'b1;
		rx_stalls_on   = 1'b1;
		rx_hold_cycles = 0;
		rx_stall_left  = 0;
		for (int i = 0; i < KEY_REGS; i++)
			mdl_key_word[i] = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_key_edges();
		test_decrypt_edges();
		test_output_backpressure();
		test_input_pause();
		test_random_messages();

		rx_stalls_on = 1'b0;
		settle_block();
		if (fail_count == 0)
			$display("cyrillic_vigenere_cipher_top regression: pass");
		else
			$display("cyrillic_vigenere_cipher_top regression: fail");
		$finish;
	end

endmodule
